// ===== src/quicksort_engine_macros.svh =====
// Assertion helpers for the quicksort engine.
`ifndef QUICKSORT_ENGINE_MACROS_SVH
`define QUICKSORT_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define QSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define QSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qse_pkg.sv =====
package qse_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // one stacked sub-range, inclusive bounds
  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SWAP,
    S_FIN_RD,
    S_FIN_LO,
    S_FIN_HI,
    S_PUSH1,
    S_PUSH2,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIVOT,
    OP_SCAN_RD,
    OP_LP_INC,
    OP_HP_DEC,
    OP_SWAP_LO,
    OP_SWAP_HI,
    OP_FIN_RD,
    OP_FIN_LO,
    OP_FIN_HI,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_OUT_RD,
    OP_OUT_LD,
    OP_OUT_NEXT
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic lp_gt_hp;
    logic a_le_piv;
    logic b_gt_piv;
    logic level_zero;
    logic at_last;
  } status_t;

endpackage

// ===== src/qse_dpath.sv =====
module qse_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  qse_pkg::op_t     op,
  input  qse_pkg::data_t   in_value,
  output qse_pkg::status_t status,
  output qse_pkg::data_t   out_value,
  output logic             out_last
);

  // element RAM and range stack RAM
  qse_pkg::data_t  elem_mem  [qse_pkg::DEPTH];
  qse_pkg::range_t stack_mem [qse_pkg::DEPTH];

  qse_pkg::cnt_t   count_r, level_r, lp_r;
  qse_pkg::idx_t   lo_r, hi_r, hp_r, k_r;
  qse_pkg::data_t  pivot_r, tmp_r, rd_a_r, rd_b_r, out_value_r;
  qse_pkg::range_t stk_rd_r, push_a_r, push_b_r;
  logic            push_a_ok_r, push_b_ok_r, out_last_r;

  qse_pkg::idx_t   addr_a, addr_b, wr_addr, stk_wr_addr;
  qse_pkg::data_t  wr_data;
  qse_pkg::range_t stk_wr_data, left_rng, right_rng;
  logic            wr_en, stk_wr_en, left_ok, right_ok, left_first, at_last;
  qse_pkg::cnt_t   cnt_m1, lvl_m1;
  qse_pkg::idx_t   dl, dr;

  assign cnt_m1  = count_r - qse_pkg::cnt_t'(1);
  assign lvl_m1  = level_r - qse_pkg::cnt_t'(1);
  assign at_last = (k_r == cnt_m1[qse_pkg::IDX_W-1:0]);

  // split of the finished partition into its two sub-ranges
  assign dl         = hp_r - lo_r;
  assign dr         = hi_r - hp_r;
  assign left_ok    = (dl >= qse_pkg::idx_t'(2));
  assign right_ok   = (dr >= qse_pkg::idx_t'(2));
  assign left_first = (dl > dr);
  assign left_rng   = '{lo: lo_r, hi: hp_r - qse_pkg::idx_t'(1)};
  assign right_rng  = '{lo: hp_r + qse_pkg::idx_t'(1), hi: hi_r};

  // element RAM port selection
  always_comb begin
    addr_a  = lp_r[qse_pkg::IDX_W-1:0];
    addr_b  = hp_r;
    wr_en   = 1'b0;
    wr_addr = lp_r[qse_pkg::IDX_W-1:0];
    wr_data = rd_b_r;
    case (op)
      qse_pkg::OP_RANGE:  addr_a = stk_rd_r.lo;
      qse_pkg::OP_OUT_RD: addr_a = k_r;
      qse_pkg::OP_LOAD: begin
        wr_en   = !count_r[qse_pkg::IDX_W];
        wr_addr = count_r[qse_pkg::IDX_W-1:0];
        wr_data = in_value;
      end
      qse_pkg::OP_SWAP_LO: wr_en = 1'b1;
      qse_pkg::OP_SWAP_HI: begin
        wr_en   = 1'b1;
        wr_addr = hp_r;
        wr_data = tmp_r;
      end
      qse_pkg::OP_FIN_LO: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
      end
      qse_pkg::OP_FIN_HI: begin
        wr_en   = 1'b1;
        wr_addr = hp_r;
        wr_data = pivot_r;
      end
      default: ;
    endcase
  end

  // range stack write port
  always_comb begin
    stk_wr_en   = 1'b0;
    stk_wr_addr = level_r[qse_pkg::IDX_W-1:0];
    stk_wr_data = push_a_r;
    case (op)
      qse_pkg::OP_INIT: begin
        stk_wr_en   = (count_r > qse_pkg::cnt_t'(1));
        stk_wr_addr = '0;
        stk_wr_data = '{lo: '0, hi: cnt_m1[qse_pkg::IDX_W-1:0]};
      end
      qse_pkg::OP_PUSH_A: stk_wr_en = push_a_ok_r && !level_r[qse_pkg::IDX_W];
      qse_pkg::OP_PUSH_B: begin
        stk_wr_en   = push_b_ok_r && !level_r[qse_pkg::IDX_W];
        stk_wr_data = push_b_r;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      elem_mem[wr_addr] <= wr_data;
    end
    rd_a_r <= elem_mem[addr_a];
    rd_b_r <= elem_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stack_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (op == qse_pkg::OP_POP) begin
      stk_rd_r <= stack_mem[lvl_m1[qse_pkg::IDX_W-1:0]];
    end
  end

  // element count and stack level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      level_r <= '0;
    end else begin
      case (op)
        qse_pkg::OP_LOAD: begin
          if (!count_r[qse_pkg::IDX_W]) count_r <= count_r + qse_pkg::cnt_t'(1);
        end
        qse_pkg::OP_INIT: begin
          level_r <= (count_r > qse_pkg::cnt_t'(1)) ? qse_pkg::cnt_t'(1) : '0;
        end
        qse_pkg::OP_POP: level_r <= lvl_m1;
        qse_pkg::OP_PUSH_A, qse_pkg::OP_PUSH_B: begin
          if (stk_wr_en) level_r <= level_r + qse_pkg::cnt_t'(1);
        end
        qse_pkg::OP_OUT_NEXT: begin
          if (at_last) count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // pointers, pivot and output word
  always_ff @(posedge clk) begin
    case (op)
      qse_pkg::OP_INIT: k_r <= '0;
      qse_pkg::OP_RANGE: begin
        lo_r <= stk_rd_r.lo;
        hi_r <= stk_rd_r.hi;
      end
      qse_pkg::OP_PIVOT: begin
        pivot_r <= rd_a_r;
        lp_r    <= {1'b0, lo_r} + qse_pkg::cnt_t'(1);
        hp_r    <= hi_r;
      end
      qse_pkg::OP_LP_INC: lp_r <= lp_r + qse_pkg::cnt_t'(1);
      qse_pkg::OP_HP_DEC: hp_r <= hp_r - qse_pkg::idx_t'(1);
      qse_pkg::OP_SWAP_LO: tmp_r <= rd_a_r;
      qse_pkg::OP_SWAP_HI: begin
        lp_r <= lp_r + qse_pkg::cnt_t'(1);
        hp_r <= hp_r - qse_pkg::idx_t'(1);
      end
      qse_pkg::OP_FIN_HI: begin
        // larger part goes on the stack first
        push_a_r    <= left_first ? left_rng : right_rng;
        push_a_ok_r <= left_first ? left_ok : right_ok;
        push_b_r    <= left_first ? right_rng : left_rng;
        push_b_ok_r <= left_first ? right_ok : left_ok;
      end
      qse_pkg::OP_OUT_LD: begin
        out_value_r <= rd_a_r;
        out_last_r  <= at_last;
      end
      qse_pkg::OP_OUT_NEXT: k_r <= k_r + qse_pkg::idx_t'(1);
      default: ;
    endcase
  end

  assign status.lp_gt_hp   = (lp_r > {1'b0, hp_r});
  assign status.a_le_piv   = (rd_a_r <= pivot_r);
  assign status.b_gt_piv   = (rd_b_r > pivot_r);
  assign status.level_zero = (level_r == '0);
  assign status.at_last    = at_last;

  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

// ===== src/qse_ctrl.sv =====
module qse_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  input  logic             out_ready,
  input  qse_pkg::status_t status,
  output qse_pkg::op_t     op,
  output logic             in_ready,
  output logic             out_valid
);

  qse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qse_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer: load, partition loop over the range stack, then unload
  always_comb begin
    state_nxt = state_r;
    op        = qse_pkg::OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      qse_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = qse_pkg::OP_LOAD;
          if (in_last) state_nxt = qse_pkg::S_INIT;
        end
      end
      qse_pkg::S_INIT: begin
        op        = qse_pkg::OP_INIT;
        state_nxt = qse_pkg::S_POP;
      end
      qse_pkg::S_POP: begin
        if (status.level_zero) begin
          state_nxt = qse_pkg::S_OUT_RD;
        end else begin
          op        = qse_pkg::OP_POP;
          state_nxt = qse_pkg::S_RANGE;
        end
      end
      qse_pkg::S_RANGE: begin
        op        = qse_pkg::OP_RANGE;
        state_nxt = qse_pkg::S_PIVOT;
      end
      qse_pkg::S_PIVOT: begin
        op        = qse_pkg::OP_PIVOT;
        state_nxt = qse_pkg::S_SCAN_RD;
      end
      qse_pkg::S_SCAN_RD: begin
        op        = qse_pkg::OP_SCAN_RD;
        state_nxt = qse_pkg::S_SCAN_CMP;
      end
      qse_pkg::S_SCAN_CMP: begin
        // pointers crossed: partition done
        if (status.lp_gt_hp) begin
          state_nxt = qse_pkg::S_FIN_RD;
        end else if (status.a_le_piv) begin
          op        = qse_pkg::OP_LP_INC;
          state_nxt = qse_pkg::S_SCAN_RD;
        end else if (status.b_gt_piv) begin
          op        = qse_pkg::OP_HP_DEC;
          state_nxt = qse_pkg::S_SCAN_RD;
        end else begin
          op        = qse_pkg::OP_SWAP_LO;
          state_nxt = qse_pkg::S_SWAP;
        end
      end
      qse_pkg::S_SWAP: begin
        op        = qse_pkg::OP_SWAP_HI;
        state_nxt = qse_pkg::S_SCAN_RD;
      end
      qse_pkg::S_FIN_RD: begin
        op        = qse_pkg::OP_FIN_RD;
        state_nxt = qse_pkg::S_FIN_LO;
      end
      qse_pkg::S_FIN_LO: begin
        op        = qse_pkg::OP_FIN_LO;
        state_nxt = qse_pkg::S_FIN_HI;
      end
      qse_pkg::S_FIN_HI: begin
        op        = qse_pkg::OP_FIN_HI;
        state_nxt = qse_pkg::S_PUSH1;
      end
      qse_pkg::S_PUSH1: begin
        op        = qse_pkg::OP_PUSH_A;
        state_nxt = qse_pkg::S_PUSH2;
      end
      qse_pkg::S_PUSH2: begin
        op        = qse_pkg::OP_PUSH_B;
        state_nxt = qse_pkg::S_POP;
      end
      qse_pkg::S_OUT_RD: begin
        op        = qse_pkg::OP_OUT_RD;
        state_nxt = qse_pkg::S_OUT_LD;
      end
      qse_pkg::S_OUT_LD: begin
        op        = qse_pkg::OP_OUT_LD;
        state_nxt = qse_pkg::S_OUT_WAIT;
      end
      qse_pkg::S_OUT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          op        = qse_pkg::OP_OUT_NEXT;
          state_nxt = status.at_last ? qse_pkg::S_LOAD : qse_pkg::S_OUT_RD;
        end
      end
      default: state_nxt = qse_pkg::S_LOAD;
    endcase
  end

endmodule

// ===== src/quicksort_engine.sv =====
// Load: one input word per cycle into the element RAM (up to 64 words, extras dropped).
// Sort: each partition scans its range with two pointers and swaps pairs, paced by the
//   single write port and registered reads of the element RAM.
// Unload: words wait for out_ready; the next set is taken after the flagged last word.
// Reset clears the sequencer, element count and stack level; the element RAM is not
//   cleared, only entries written for the current set are read.
`include "quicksort_engine_macros.svh"

module quicksort_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [qse_pkg::DATA_W-1:0] in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [qse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                  out_end_of_set
);

  qse_pkg::op_t     op;
  qse_pkg::status_t status;
  logic             last_in_acc, last_out_acc;

  qse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .out_ready (out_ready),
    .status    (status),
    .op        (op),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  qse_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_value  (in_value),
    .status    (status),
    .out_value (out_sorted_value),
    .out_last  (out_end_of_set)
  );

  // closing words accepted on either side
  assign last_in_acc  = in_valid && in_ready && in_last;
  assign last_out_acc = out_valid && out_ready && out_end_of_set;

  // loading and unloading never overlap
  `QSE_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "load and unload overlap")
  // closing word of a set stops loading
  `QSE_ASSERT_NXT(a_last_stops_load, last_in_acc, !in_ready, "load after last word")
  // final output word returns to loading
  `QSE_ASSERT_NXT(a_end_to_load, last_out_acc, in_ready && !out_valid, "no return to load")

endmodule
